// ===== hdl/ites_pkg.sv =====
// shared types, constants and helpers for the integer token extract and sort core
package ites_pkg;

   // capacity of the value store
   localparam int MAX_COUNT = 32;
   localparam int ADDR_W    = $clog2(MAX_COUNT);
   localparam int CNT_W     = $clog2(MAX_COUNT + 1);

   // field widths
   localparam int VALUE_W    = 32;
   localparam int DIGIT_W    = 4;
   localparam int MASK_W     = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 2;

   // request kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // list tags
   localparam logic TAG_FOUND  = 1'b0;
   localparam logic TAG_SORTED = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_0 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_1 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_3 = 2'd3;

   // character codes
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   // magnitude cap while accumulating and the positive saturation value
   localparam logic [VALUE_W-1:0] MAG_CAP = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] POS_MAX = 32'h7FFF_FFFF;

   // powers of ten used for the digit count
   localparam int NUM_POW = 9;
   localparam logic [VALUE_W-1:0] DEC_POW [NUM_POW] = '{
      32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000,
      32'd10000000, 32'd100000000, 32'd1000000000
   };

   // one stored value with its digit count
   typedef struct packed {
      logic [DIGIT_W-1:0] digits;
      logic [VALUE_W-1:0] value;
   } entry_type;

   // store writes and run start from the scanner to the sorter
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      entry_type         wdata;
      logic              start;
      logic [CNT_W-1:0]  count;
   } scan_req_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_SCAN,
      ST_NONE,
      ST_EMIT_RD,
      ST_EMIT_OUT,
      ST_LOAD_RD,
      ST_LOAD,
      ST_CMP_RD,
      ST_CMP,
      ST_STORE,
      ST_SORTED_RD,
      ST_SORTED_OUT
   } seq_state_type;

   // decimal digits of a magnitude, zero counts one
   function automatic logic [DIGIT_W-1:0] digits_of_mag(input logic [VALUE_W-1:0] mag);
      logic [DIGIT_W-1:0] cnt;
      cnt = DIGIT_W'(1);
      for (int p = 0; p < NUM_POW; p++) begin
         if (mag >= DEC_POW[p]) cnt = cnt + DIGIT_W'(1);
      end
      return cnt;
   endfunction

endpackage

// ===== hdl/integer_token_extract_sort_core.sv =====
// top level of the integer token extract and sort core
// Text bytes (req_tuser 0) are taken one per cycle while the sequencer is idle; each
// feeds the scanner's multiply-by-ten accumulate and produces no result. An end-of-text
// item (req_tuser 1) holds req_tready low while a single sequencer walks the 32-entry
// value store through one read port and one digit-count comparator: with values found
// it emits the found-order list, runs the exchange sort and emits the sorted list,
// waiting while rsp_tready is low; a run with no values yields one none-found result.
// The next text byte is accepted while the final result still waits in the
// output register. No clearing pass is needed after reset.
module integer_token_extract_sort_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_wr_en,
   input  logic [ites_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ites_pkg::MASK_W-1:0]           csr_wr_data,
   // text input
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [ites_pkg::REQ_DATA_W-1:0]       req_tdata,   // text_byte
   input  logic                                  req_tuser,   // kind
   // results
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [ites_pkg::RSP_DATA_W-1:0]       rsp_tdata,   // number_value, digit_count, pad
   output logic [ites_pkg::RSP_USER_W-1:0]       rsp_tuser,   // list_tag, none_found
   output logic                                  rsp_tlast    // last
);
   import ites_pkg::*;

   scan_req_type        scan_req;
   logic                seq_idle;
   logic                in_accept;
   logic                rsp_list_tag;
   logic [VALUE_W-1:0]  rsp_value;
   logic [DIGIT_W-1:0]  rsp_digits;
   logic                rsp_none;

   // input transaction
   assign req_tready = seq_idle;
   assign in_accept  = req_tvalid && req_tready;

   // byte scanner
   ites_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .in_accept   (in_accept),
      .in_kind     (req_tuser),
      .in_byte     (req_tdata),
      .scan_req    (scan_req)
   );

   // store, sort sequencer and output register
   ites_sort u_sort (
      .clock        (clock),
      .reset        (reset),
      .scan_req     (scan_req),
      .idle         (seq_idle),
      .rsp_tready   (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_list_tag (rsp_list_tag),
      .rsp_value    (rsp_value),
      .rsp_digits   (rsp_digits),
      .rsp_none     (rsp_none),
      .rsp_last     (rsp_tlast)
   );

   // result packing
   assign rsp_tdata = {(RSP_DATA_W-VALUE_W-DIGIT_W)'(0), rsp_digits, rsp_value};
   assign rsp_tuser = {rsp_none, rsp_list_tag};

endmodule

// ===== hdl/ites_scan.sv =====
// byte scanner: delimiter masks, word tracking, decimal accumulate and value capture
module ites_scan (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [ites_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ites_pkg::MASK_W-1:0]           csr_wr_data,
   input  logic                                  in_accept,
   input  logic                                  in_kind,
   input  logic [7:0]                            in_byte,
   output ites_pkg::scan_req_type                scan_req
);
   import ites_pkg::*;

   logic [4*MASK_W-1:0] mask_ff;
   logic                in_word_ff, in_word_in;
   logic                neg_ff, neg_in;
   logic                invalid_ff, invalid_in;
   logic                has_digit_ff, has_digit_in;
   logic [VALUE_W-1:0]  mag_ff, mag_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   logic                is_sep;
   logic                is_digit;
   logic [3:0]          digit_val;
   logic [VALUE_W+3:0]  mag_x10;
   logic                close;
   logic                keep;
   logic [VALUE_W-1:0]  close_value;

   // delimiter mask registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MASK_0: mask_ff[0*MASK_W +: MASK_W] <= csr_wr_data;
            CSR_MASK_1: mask_ff[1*MASK_W +: MASK_W] <= csr_wr_data;
            CSR_MASK_2: mask_ff[2*MASK_W +: MASK_W] <= csr_wr_data;
            CSR_MASK_3: mask_ff[3*MASK_W +: MASK_W] <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // byte classification
   assign is_sep    = (in_byte == CHAR_SPACE) ||
                      ((in_byte >= CHAR_TAB) && (in_byte <= CHAR_CR)) ||
                      mask_ff[in_byte];
   assign is_digit  = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
   assign digit_val = 4'(in_byte - CHAR_ZERO);

   // magnitude times ten plus digit
   assign mag_x10 = {1'b0, mag_ff, 3'b000} + {3'b000, mag_ff, 1'b0} +
                    {(VALUE_W)'(0), digit_val};

   // closing a word on a separator or end of text
   assign close = in_accept && ((in_kind == KIND_END) || is_sep);
   assign keep  = close && in_word_ff && !invalid_ff && has_digit_ff &&
                  (count_ff < CNT_W'(MAX_COUNT));
   assign close_value = neg_ff ? (VALUE_W'(0) - mag_ff) :
                        ((mag_ff >= MAG_CAP) ? POS_MAX : mag_ff);

   // word state next values
   always_comb begin
      in_word_in   = in_word_ff;
      neg_in       = neg_ff;
      invalid_in   = invalid_ff;
      has_digit_in = has_digit_ff;
      mag_in       = mag_ff;
      count_in     = count_ff;
      if (keep) count_in = count_ff + CNT_W'(1);
      if (in_accept) begin
         if (close) begin
            in_word_in   = 1'b0;
            neg_in       = 1'b0;
            invalid_in   = 1'b0;
            has_digit_in = 1'b0;
            mag_in       = '0;
            if (in_kind == KIND_END) count_in = '0;
         end else if (!in_word_ff) begin
            in_word_in = 1'b1;
            if (in_byte == CHAR_MINUS) begin
               neg_in = 1'b1;
            end else if (is_digit) begin
               has_digit_in = 1'b1;
               mag_in       = {(VALUE_W-4)'(0), digit_val};
            end else begin
               invalid_in = 1'b1;
            end
         end else if (is_digit) begin
            mag_in       = (mag_x10 > {4'b0000, MAG_CAP}) ? MAG_CAP : mag_x10[VALUE_W-1:0];
            has_digit_in = 1'b1;
         end else begin
            invalid_in = 1'b1;
         end
      end
   end

   // word state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_word_ff   <= 1'b0;
         neg_ff       <= 1'b0;
         invalid_ff   <= 1'b0;
         has_digit_ff <= 1'b0;
         mag_ff       <= '0;
         count_ff     <= '0;
      end else begin
         in_word_ff   <= in_word_in;
         neg_ff       <= neg_in;
         invalid_ff   <= invalid_in;
         has_digit_ff <= has_digit_in;
         mag_ff       <= mag_in;
         count_ff     <= count_in;
      end
   end

   // store write and run start toward the sorter
   always_comb begin
      scan_req.we           = keep;
      scan_req.addr         = count_ff[ADDR_W-1:0];
      scan_req.wdata.value  = close_value;
      scan_req.wdata.digits = digits_of_mag(mag_ff);
      scan_req.start        = in_accept && (in_kind == KIND_END);
      scan_req.count        = count_ff + CNT_W'(keep);
   end

endmodule

// ===== hdl/ites_sort.sv =====
// value store, exchange sort sequencer with one shared compare, and result register
module ites_sort (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ites_pkg::scan_req_type                scan_req,
   output logic                                  idle,
   input  logic                                  rsp_tready,
   output logic                                  rsp_valid,
   output logic                                  rsp_list_tag,
   output logic [ites_pkg::VALUE_W-1:0]          rsp_value,
   output logic [ites_pkg::DIGIT_W-1:0]          rsp_digits,
   output logic                                  rsp_none,
   output logic                                  rsp_last
);
   import ites_pkg::*;

   seq_state_type      state_ff, state_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic [ADDR_W-1:0]  i_ff, i_in;
   logic [CNT_W-1:0]   j_ff, j_in;
   entry_type          cur_ff, cur_in;

   entry_type          mem_ff [MAX_COUNT];
   entry_type          rdata_ff;
   logic [ADDR_W-1:0]  rd_addr;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_addr;
   entry_type          mem_wdata;
   logic               sort_we;
   logic [ADDR_W-1:0]  sort_addr;
   entry_type          sort_wdata;

   logic               out_free;
   logic               load_out;
   logic               out_tag_in, out_none_in, out_last_in;
   entry_type          out_entry_in;
   logic               valid_ff;
   logic               tag_ff, none_ff, last_ff;
   entry_type          out_entry_ff;

   assign out_free = !valid_ff || rsp_tready;
   assign idle     = (state_ff == ST_SCAN);

   // sequencer next state and datapath controls
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      cur_in       = cur_ff;
      rd_addr      = k_ff[ADDR_W-1:0];
      sort_we      = 1'b0;
      sort_addr    = j_ff[ADDR_W-1:0];
      sort_wdata   = cur_ff;
      load_out     = 1'b0;
      out_tag_in   = TAG_FOUND;
      out_none_in  = 1'b0;
      out_last_in  = 1'b0;
      out_entry_in = rdata_ff;
      unique case (state_ff)
         ST_SCAN: begin
            if (scan_req.start) begin
               n_in     = scan_req.count;
               k_in     = '0;
               state_in = (scan_req.count == '0) ? ST_NONE : ST_EMIT_RD;
            end
         end
         ST_NONE: begin
            out_entry_in = '0;
            out_none_in  = 1'b1;
            out_last_in  = 1'b1;
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (out_free) begin
               load_out = 1'b1;
               if (k_ff + CNT_W'(1) == n_ff) begin
                  i_in = '0;
                  k_in = '0;
                  state_in = (n_ff == CNT_W'(1)) ? ST_SORTED_RD : ST_LOAD_RD;
               end else begin
                  k_in     = k_ff + CNT_W'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         ST_LOAD_RD: begin
            rd_addr  = i_ff;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            rd_addr  = i_ff;
            cur_in   = rdata_ff;
            j_in     = {1'b0, i_ff} + CNT_W'(1);
            state_in = ST_CMP_RD;
         end
         ST_CMP_RD: begin
            rd_addr  = j_ff[ADDR_W-1:0];
            state_in = ST_CMP;
         end
         ST_CMP: begin
            rd_addr = j_ff[ADDR_W-1:0];
            // swap when the held entry has more digits
            if (cur_ff.digits > rdata_ff.digits) begin
               sort_we = 1'b1;
               cur_in  = rdata_ff;
            end
            if (j_ff + CNT_W'(1) == n_ff) begin
               state_in = ST_STORE;
            end else begin
               j_in     = j_ff + CNT_W'(1);
               state_in = ST_CMP_RD;
            end
         end
         ST_STORE: begin
            sort_we   = 1'b1;
            sort_addr = i_ff;
            if ({1'b0, i_ff} + CNT_W'(2) == n_ff) begin
               k_in     = '0;
               state_in = ST_SORTED_RD;
            end else begin
               i_in     = i_ff + ADDR_W'(1);
               state_in = ST_LOAD_RD;
            end
         end
         ST_SORTED_RD: begin
            state_in = ST_SORTED_OUT;
         end
         ST_SORTED_OUT: begin
            out_tag_in  = TAG_SORTED;
            out_last_in = (k_ff + CNT_W'(1) == n_ff);
            if (out_free) begin
               load_out = 1'b1;
               if (k_ff + CNT_W'(1) == n_ff) begin
                  state_in = ST_SCAN;
               end else begin
                  k_in     = k_ff + CNT_W'(1);
                  state_in = ST_SORTED_RD;
               end
            end
         end
         default: state_in = ST_SCAN;
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SCAN;
         n_ff     <= '0;
         k_ff     <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         k_ff     <= k_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // store write port shared by the scanner and the sort
   assign mem_we    = scan_req.we || sort_we;
   assign mem_addr  = scan_req.we ? scan_req.addr : sort_addr;
   assign mem_wdata = scan_req.we ? scan_req.wdata : sort_wdata;

   // value store with registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem_ff[mem_addr] <= mem_wdata;
      rdata_ff <= mem_ff[rd_addr];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load_out) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         tag_ff       <= out_tag_in;
         none_ff      <= out_none_in;
         last_ff      <= out_last_in;
         out_entry_ff <= out_entry_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_list_tag = tag_ff;
   assign rsp_value    = out_entry_ff.value;
   assign rsp_digits   = out_entry_ff.digits;
   assign rsp_none     = none_ff;
   assign rsp_last     = last_ff;

`ifndef SYNTH
   // a pending result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      (load_out && valid_ff) |-> rsp_tready)
      else $error("result register overwritten");

   // the inner index stays below the run count
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (j_ff < n_ff))
      else $error("sort index out of range");

   // scanner writes only while the sequencer waits for text
   assert property (@(posedge clock) disable iff (reset)
      scan_req.we |-> (state_ff == ST_SCAN))
      else $error("store written by scanner during sort");

   // the empty-run result closes the run
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && none_ff) |-> last_ff)
      else $error("none-found result not last");
`endif

endmodule

// ===== bench/tb_integer_token_extract_sort_core.sv =====
`timescale 1ns / 100ps
// testbench for the integer token extract and sort core: random text runs checked by a predictor
import ites_pkg::*;

// one expected result transaction
typedef struct {
   logic               tag;
   logic [VALUE_W-1:0] value;
   logic [DIGIT_W-1:0] digits;
   logic               no_values;
   logic               is_last;
} token_result_type;

// scoreboard: follows the word scanner and builds both result lists at end of text
class token_list_predictor;
   localparam int RADIX = 10;

   logic [MASK_W-1:0]  delim_mask [4];
   bit                 in_word;
   bit                 word_negative;
   bit                 word_bad;
   bit                 word_has_digit;
   logic [VALUE_W-1:0] word_mag;
   logic [VALUE_W-1:0] found_values [$];
   token_result_type   expected_tokens [$];
   int                 mismatches;

   function new();
      foreach (delim_mask[i]) delim_mask[i] = '0;
      mismatches = 0;
      clear_word();
   endfunction

   function void set_mask(int idx, logic [MASK_W-1:0] bits);
      delim_mask[idx] = bits;
   endfunction

   function int pending();
      return expected_tokens.size();
   endfunction

   function bit is_separator(logic [7:0] b);
      return (b == CHAR_SPACE) || (b >= CHAR_TAB && b <= CHAR_CR) || delim_mask[b[7:6]][b[5:0]];
   endfunction

   function void clear_word();
      in_word        = 1'b0;
      word_negative  = 1'b0;
      word_bad       = 1'b0;
      word_has_digit = 1'b0;
      word_mag       = '0;
   endfunction

   // keep a finished integer word, saturated, while the store has room
   function void close_word();
      logic [VALUE_W-1:0] v;
      if (in_word && !word_bad && word_has_digit && found_values.size() < MAX_COUNT) begin
         if (word_negative) v = -word_mag;
         else v = (word_mag >= MAG_CAP) ? POS_MAX : word_mag;
         found_values.push_back(v);
      end
      clear_word();
   endfunction

   // decimal digits of the magnitude, zero has one
   function logic [DIGIT_W-1:0] count_digits(logic [VALUE_W-1:0] v);
      logic [VALUE_W-1:0] mag;
      logic [DIGIT_W-1:0] d;
      mag = v[VALUE_W-1] ? -v : v;
      d = DIGIT_W'(1);
      while (mag >= RADIX) begin
         mag = mag / RADIX;
         d++;
      end
      return d;
   endfunction

   // one accepted input transaction
   function void note_text_item(logic kind, logic [7:0] b);
      logic [2*VALUE_W-1:0] grown;
      logic [VALUE_W-1:0]   ordered [$];
      logic [VALUE_W-1:0]   swap;
      if (kind == KIND_BYTE) begin
         if (is_separator(b)) begin
            close_word();
         end else if (!in_word) begin
            in_word = 1'b1;
            if (b == CHAR_MINUS) begin
               word_negative = 1'b1;
            end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
               word_has_digit = 1'b1;
               word_mag = VALUE_W'(b - CHAR_ZERO);
            end else begin
               word_bad = 1'b1;
            end
         end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            grown = 64'(word_mag) * RADIX + 64'(b - CHAR_ZERO);
            word_mag = (grown > 64'(MAG_CAP)) ? MAG_CAP : grown[VALUE_W-1:0];
            word_has_digit = 1'b1;
         end else begin
            word_bad = 1'b1;
         end
         return;
      end

      // end of text: close any open word, then both lists
      close_word();
      if (found_values.size() == 0) begin
         expected_tokens.push_back('{TAG_FOUND, '0, '0, 1'b1, 1'b1});
         return;
      end
      foreach (found_values[k])
         expected_tokens.push_back('{TAG_FOUND, found_values[k],
                                     count_digits(found_values[k]), 1'b0, 1'b0});
      ordered = found_values;
      for (int i = 0; i + 1 < ordered.size(); i++) begin
         for (int j = i + 1; j < ordered.size(); j++) begin
            if (count_digits(ordered[i]) > count_digits(ordered[j])) begin
               swap       = ordered[i];
               ordered[i] = ordered[j];
               ordered[j] = swap;
            end
         end
      end
      foreach (ordered[k])
         expected_tokens.push_back('{TAG_SORTED, ordered[k], count_digits(ordered[k]), 1'b0,
                                     k == ordered.size() - 1});
      found_values.delete();
   endfunction

   function void compare_field(string field, logic signed [63:0] want, logic signed [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endfunction

   // one accepted result transaction against the oldest expectation
   function void check_token(logic [RSP_DATA_W-1:0] tdata, logic [RSP_USER_W-1:0] tuser,
                             logic tlast);
      token_result_type want;
      if (expected_tokens.size() == 0) begin
         $error("unexpected result: number_value %0d", $signed(tdata[VALUE_W-1:0]));
         mismatches++;
         return;
      end
      want = expected_tokens.pop_front();
      compare_field("list_tag", want.tag, tuser[0]);
      compare_field("number_value", $signed(want.value), $signed(tdata[VALUE_W-1:0]));
      compare_field("digit_count", want.digits, tdata[VALUE_W +: DIGIT_W]);
      compare_field("none_found", want.no_values, tuser[1]);
      compare_field("last", want.is_last, tlast);
   endfunction
endclass

module tb_integer_token_extract_sort_core;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_VT = 8'h0B;
   localparam logic [7:0] CHAR_FF = 8'h0C;
   localparam logic [7:0] BLANKS [6] = '{CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR};
   localparam logic [CSR_IDX_W-1:0] MASK_INDEX [4] = '{CSR_MASK_0, CSR_MASK_1, CSR_MASK_2,
                                                       CSR_MASK_3};
   localparam int DRAIN_CYCLES = 4;

   // zero with a minus, lone minus, minus inside a word, high byte and nul in a word,
   // and a word still open at end of text
   localparam logic [7:0] OPENING_TEXT [18] = '{
      CHAR_MINUS, CHAR_ZERO, CHAR_SPACE, CHAR_MINUS, CHAR_CR, CHAR_ZERO + 8'd4, CHAR_MINUS,
      CHAR_ZERO + 8'd2, CHAR_LF, CHAR_ZERO + 8'd8, 8'hFF, CHAR_TAB, 8'h00, CHAR_VT,
      CHAR_NINE, CHAR_FF, CHAR_MINUS, CHAR_ZERO + 8'd7
   };

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [MASK_W-1:0]     csr_wr_data;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;

   int                    sender_idle_pct;
   int                    stall_pct;
   int                    items_sent;
   token_list_predictor   predictor;

   integer_token_extract_sort_core u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // result side: random stall, check on every accepted transaction
   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         predictor.check_token(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // one input transaction, with random idle cycles ahead of it
   task automatic send_item(input logic kind, input logic [7:0] b);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         do @(negedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predictor.note_text_item(kind, b);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (predictor.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_masks(input logic [MASK_W-1:0] m0, input logic [MASK_W-1:0] m1,
                              input logic [MASK_W-1:0] m2, input logic [MASK_W-1:0] m3);
      logic [MASK_W-1:0] bits [4];
      bits = '{m0, m1, m2, m3};
      for (int i = 0; i < 4; i++) begin
         csr_wr_en   = 1'b1;
         csr_index   = MASK_INDEX[i];
         csr_wr_data = bits[i];
         predictor.set_mask(i, bits[i]);
         @(negedge clock);
      end
      csr_wr_en = 1'b0;
   endtask

   function automatic logic [MASK_W-1:0] random_mask(bit sparse);
      logic [MASK_W-1:0] bits;
      bits = {$urandom, $urandom};
      if (sparse) bits = bits & {$urandom, $urandom};
      return bits;
   endfunction

   // digits and minus stay word bytes in mask 0
   function automatic logic [MASK_W-1:0] keep_number_bytes(logic [MASK_W-1:0] bits);
      bits[CHAR_MINUS[5:0]] = 1'b0;
      for (int d = 0; d < 10; d++) bits[CHAR_ZERO[5:0] + d] = 1'b0;
      return bits;
   endfunction

   // whitespace mostly, otherwise a byte the current masks mark
   task automatic send_separator();
      logic [7:0] b;
      logic [7:0] cand;
      b = BLANKS[$urandom_range(5)];
      if ($urandom_range(2) == 0) begin
         repeat (8) begin
            cand = 8'($urandom);
            if (predictor.is_separator(cand)) b = cand;
         end
      end
      send_item(KIND_BYTE, b);
   endtask

   // integer words of all lengths, malformed words and single stray bytes
   task automatic send_word();
      int    roll;
      int    len;
      string num;
      roll = $urandom_range(99);
      if (roll < 60) begin
         if ($urandom_range(2) == 0) send_item(KIND_BYTE, CHAR_MINUS);
         len = $urandom_range(99);
         if (len < 10) begin
            // around the int32 limits
            num = $sformatf("%0d", 64'd2147483646 + 64'($urandom_range(3)));
            for (int i = 0; i < num.len(); i++) send_item(KIND_BYTE, num[i]);
         end else begin
            len = (len < 70) ? $urandom_range(1, 3) :
                  (len < 85) ? $urandom_range(4, 9) : $urandom_range(10, 12);
            repeat (len) send_item(KIND_BYTE, CHAR_ZERO + 8'($urandom_range(9)));
         end
      end else if (roll < 80) begin
         repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(2))
               0: send_item(KIND_BYTE, CHAR_ZERO + 8'($urandom_range(9)));
               1: send_item(KIND_BYTE, CHAR_MINUS);
               default: send_item(KIND_BYTE, 8'($urandom));
            endcase
         end
      end else if (roll < 90) begin
         send_item(KIND_BYTE, CHAR_MINUS);
      end else begin
         send_item(KIND_BYTE, 8'($urandom));
      end
   endtask

   // one text run closed by end of text; short words fill the store quickly
   task automatic send_run(input int words, input bit short_words);
      for (int w = 0; w < words; w++) begin
         if (short_words) begin
            if ($urandom_range(3) == 0) send_item(KIND_BYTE, CHAR_MINUS);
            send_item(KIND_BYTE, CHAR_ZERO + 8'($urandom_range(9)));
         end else begin
            send_word();
         end
         if (w + 1 < words || $urandom_range(1) == 0) send_separator();
      end
      send_item(KIND_END, 8'($urandom));
   endtask

   task automatic send_runs(input int item_goal, input bit overfill);
      int first;
      first = items_sent;
      if (overfill) send_run($urandom_range(MAX_COUNT + 1, MAX_COUNT + 6), 1'b1);
      while (items_sent - first < item_goal) send_run($urandom_range(0, 8), 1'b0);
   endtask

   // run limit
   initial begin
      #12_000_000;
      $display("integer_token_extract_sort_core: mismatch");
      $finish;
   end

   initial begin
      predictor       = new();
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_index       = CSR_MASK_0;
      csr_wr_data     = '0;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = KIND_BYTE;
      rsp_tready      = 1'b0;
      sender_idle_pct = 0;
      stall_pct       = 0;
      items_sent      = 0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // directed opening: empty text, then the odd word shapes
      write_masks('0, '0, '0, '0);
      send_item(KIND_END, 8'hFF);
      foreach (OPENING_TEXT[i]) send_item(KIND_BYTE, OPENING_TEXT[i]);
      send_item(KIND_END, 8'h00);
      send_runs(50, 1'b0);
      wait_drained();

      // sparse masks, idle sender, one run past the store size
      write_masks(keep_number_bytes(random_mask(1'b1)), random_mask(1'b1), random_mask(1'b1),
                  random_mask(1'b1));
      sender_idle_pct = 46;
      stall_pct       = 0;
      send_runs(70, 1'b1);
      wait_drained();

      // every byte a delimiter
      write_masks('1, '1, '1, '1);
      sender_idle_pct = 6;
      stall_pct       = 6;
      send_runs(20, 1'b0);
      wait_drained();

      // dense masks, stalling receiver; sender holds off once until all results are in
      write_masks(keep_number_bytes(random_mask(1'b0)), random_mask(1'b0), random_mask(1'b0),
                  random_mask(1'b0));
      sender_idle_pct = 0;
      stall_pct       = 46;
      send_run(8, 1'b0);
      wait_drained();
      send_runs(70, 1'b0);
      wait_drained();

      // masks cleared again, light idling on both sides
      write_masks('0, '0, '0, '0);
      sender_idle_pct = 6;
      stall_pct       = 6;
      send_runs(70, 1'b1);
      wait_drained();

      if (predictor.mismatches == 0 && predictor.pending() == 0)
         $display("integer_token_extract_sort_core: match");
      else
         $display("integer_token_extract_sort_core: mismatch");
      $finish;
   end
endmodule
